### src/srtl_pkg.sv
// ----------------------------------------------------------------------------
// srtl_pkg: shared types and constants for the route table lookup
// Operation codes, field widths, the write command broadcast to the peer
// cells and the lookup token handed from cell to cell.
// ----------------------------------------------------------------------------
package srtl_pkg;

    localparam int PEER_SLOTS_DEF     = 16;
    localparam int NETS_PER_HOST_DEF  = 4;
    localparam int FIRST_SCANNED_SLOT = 2;

    localparam int OP_W    = 2;
    localparam int SLOT_W  = 4;
    localparam int SUB_W   = 2;
    localparam int ADDR_W  = 32;
    localparam int COUNT_W = 3;

    typedef enum logic [OP_W-1:0] {
        OP_LOOKUP       = 2'd0,
        OP_WRITE_PEER   = 2'd1,
        OP_WRITE_SUBNET = 2'd2,
        OP_CLEAR_PEER   = 2'd3
    } op_t;

    // write command seen by every cell in the same cycle
    typedef struct packed {
        logic               wr_peer;
        logic               wr_subnet;
        logic               clr_peer;
        logic [SLOT_W-1:0]  peer_slot;
        logic [SUB_W-1:0]   subnet_slot;
        logic [ADDR_W-1:0]  address;
        logic [ADDR_W-1:0]  subnet_mask;
        logic [COUNT_W-1:0] subnet_count;
    } wr_cmd_t;

    // lookup token walking down the chain
    typedef struct packed {
        logic              active;
        logic              hit;
        logic              by_subnet;
        logic [SLOT_W-1:0] slot;
        logic [ADDR_W-1:0] address;
    } token_t;

endpackage

### src/subnet_route_table_lookup.sv
// ----------------------------------------------------------------------------
// subnet_route_table_lookup: first-match masked route lookup over peer slots
// Peer cells in a row; a lookup token walks it one cell per cycle unless held,
// and the first valid scanned peer whose subnet or own address matches claims it.
// ----------------------------------------------------------------------------
//  channel  dir  tdata                                   tuser
//  s_*      in   peer_slot, subnet_slot, address,        operation
//                subnet_mask, subnet_count
//  m_*      out  hit, matched_slot, by_subnet            -
//
//  A write or clear beat is applied in the cycle it is accepted and gives
//  no result. A lookup beat passes through the cell chain, one peer per
//  cycle while the chain is not held, and then into the output register;
//  no new beat is taken until its result is in the output register. A
//  stalled output holds the token at the chain tail.
//  Reset clears the valid marks, subnet counts and subnets.
// ----------------------------------------------------------------------------
module subnet_route_table_lookup
    import srtl_pkg::*;
#(
    parameter int PEER_SLOTS    = PEER_SLOTS_DEF,
    parameter int NETS_PER_HOST = NETS_PER_HOST_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [3:0] peer_slot, [5:4] subnet_slot, [37:6] address,
    // [69:38] subnet_mask, [72:70] subnet_count, [79:73] zero
    input  logic [79:0] s_tdata,
    // [1:0] operation
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] hit, [4:1] matched_slot, [5] by_subnet, [7:6] zero
    output logic [7:0]  m_tdata
);

    localparam int LAST = PEER_SLOTS - 1;

    logic              accept;
    op_t               op;
    wr_cmd_t           wr;
    logic              lookup;
    token_t            inject;
    token_t            tok [PEER_SLOTS];
    token_t            tail;
    logic [PEER_SLOTS-1:0] tok_active;
    logic              load;
    logic              advance;
    logic              busy_reg;
    logic              out_valid_reg;
    logic              hit_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic              by_subnet_reg;

    assign s_tready = !busy_reg;
    assign accept   = s_tvalid && s_tready;
    assign op       = op_t'(s_tuser);

    always_comb
    begin
        wr.wr_peer      = 1'b0;
        wr.wr_subnet    = 1'b0;
        wr.clr_peer     = 1'b0;
        lookup          = 1'b0;
        wr.peer_slot    = s_tdata[3:0];
        wr.subnet_slot  = s_tdata[5:4];
        wr.address      = s_tdata[37:6];
        wr.subnet_mask  = s_tdata[69:38];
        wr.subnet_count = s_tdata[72:70];
        unique case (op)
            OP_LOOKUP:       lookup       = accept;
            OP_WRITE_PEER:   wr.wr_peer   = accept;
            OP_WRITE_SUBNET: wr.wr_subnet = accept;
            OP_CLEAR_PEER:   wr.clr_peer  = accept;
            default:         lookup       = 1'b0;
        endcase
    end

    always_comb
    begin
        inject           = '0;
        inject.active    = lookup;
        inject.address   = s_tdata[37:6];
    end

    assign tail    = tok[LAST];
    assign load    = tail.active && (!out_valid_reg || m_tready);
    // hold the whole chain while the tail beat waits for the output register
    assign advance = !tail.active || load;

    for (genvar p = 0; p < PEER_SLOTS; p++)
    begin : g_cell
        token_t tok_in;

        if (p == 0)
        begin : g_head
            assign tok_in = inject;
        end
        else
        begin : g_link
            assign tok_in = tok[p-1];
        end

        srtl_cell #(
            .SLOT          (p),
            .NETS_PER_HOST (NETS_PER_HOST)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .wr      (wr),
            .tok_in  (tok_in),
            .tok_out (tok[p])
        );

        assign tok_active[p] = tok[p].active;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (lookup)
            begin
                busy_reg <= 1'b1;
            end
            else if (load)
            begin
                busy_reg <= 1'b0;
            end

            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            hit_reg       <= tail.hit;
            slot_reg      <= tail.slot;
            by_subnet_reg <= tail.by_subnet;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, by_subnet_reg, slot_reg, hit_reg};

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_single_token: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(tok_active) <= 1)
        else $error("more than one lookup token in the chain");

    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> (tok_active == '0))
        else $error("token in the chain while not busy");

    a_lookup_busy: assert property (@(posedge clk) disable iff (!rst_n)
        lookup |=> busy_reg && tok_active[0])
        else $error("accepted lookup did not enter the chain");

    a_miss_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (tail.active && !tail.hit) |-> (tail.slot == '0 && !tail.by_subnet))
        else $error("miss token carries a slot or subnet mark");

endmodule

### src/srtl_cell.sv
// ----------------------------------------------------------------------------
// srtl_cell: one peer slot of the route table
// Holds the valid mark, own address, subnet count and subnets of one peer,
// applies broadcast writes, and tests the lookup token passing through.
// ----------------------------------------------------------------------------
module srtl_cell
    import srtl_pkg::*;
#(
    parameter int SLOT          = 0,
    parameter int NETS_PER_HOST = NETS_PER_HOST_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    advance,
    input  wr_cmd_t wr,
    input  token_t  tok_in,
    output token_t  tok_out
);

    localparam int   CNT_W   = $clog2(NETS_PER_HOST + 1);
    localparam logic SCANNED = (SLOT >= FIRST_SCANNED_SLOT);

    logic              valid_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_sat;
    logic [NETS_PER_HOST-1:0] net_match;
    logic              net_hit;
    logic              own_hit;
    logic              sel;
    token_t            tok_next;
    token_t            tok_reg;

    assign sel = (int'(wr.peer_slot) == SLOT);

    always_comb
    begin
        if (int'(wr.subnet_count) > NETS_PER_HOST)
        begin
            count_sat = CNT_W'(NETS_PER_HOST);
        end
        else
        begin
            count_sat = CNT_W'(wr.subnet_count);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            count_reg <= '0;
        end
        else if (sel && wr.wr_peer)
        begin
            valid_reg <= 1'b1;
            count_reg <= count_sat;
        end
        else if (sel && wr.clr_peer)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sel && wr.wr_peer)
        begin
            addr_reg <= wr.address;
        end
    end

    for (genvar j = 0; j < NETS_PER_HOST; j++)
    begin : g_net
        logic [ADDR_W-1:0] dest_reg;
        logic [ADDR_W-1:0] mask_reg;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dest_reg <= '0;
                mask_reg <= '0;
            end
            else if (sel && wr.wr_subnet && (int'(wr.subnet_slot) == j))
            begin
                dest_reg <= wr.address;
                mask_reg <= wr.subnet_mask;
            end
        end

        assign net_match[j] = (int'(count_reg) > j) &&
                              ((tok_in.address & mask_reg) ==
                               (dest_reg & mask_reg));
    end

    assign net_hit = |net_match;
    assign own_hit = (tok_in.address == addr_reg);

    // first hit wins: an earlier cell's hit passes through untouched
    always_comb
    begin
        tok_next = tok_in;
        if (SCANNED && tok_in.active && !tok_in.hit && valid_reg)
        begin
            if (net_hit)
            begin
                tok_next.hit       = 1'b1;
                tok_next.by_subnet = 1'b1;
                tok_next.slot      = SLOT_W'(SLOT);
            end
            else if (own_hit)
            begin
                tok_next.hit       = 1'b1;
                tok_next.by_subnet = 1'b0;
                tok_next.slot      = SLOT_W'(SLOT);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else if (advance)
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

### tb/sv/tb_subnet_route_table_lookup.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_subnet_route_table_lookup: self-checking bench for the route table lookup
// Streams write, clear and lookup beats into the block and keeps a shadow copy
// of the peer table. Each lookup result is scored against a first-match scan
// of that copy. Both sides of the stream idle and stall at random, and the
// output is held off for a long stretch once.
// ----------------------------------------------------------------------------
module tb_subnet_route_table_lookup;
    import srtl_pkg::*;

    localparam int NETS         = NETS_PER_HOST_DEF;
    localparam int RANDOM_BEATS = 1600;
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 40;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct {
        op_t                op;
        logic [SLOT_W-1:0]  peer_slot;
        logic [SUB_W-1:0]   subnet_slot;
        logic [ADDR_W-1:0]  address;
        logic [ADDR_W-1:0]  subnet_mask;
        logic [COUNT_W-1:0] subnet_count;
        bit                 drain_first;
    } beat_t;

    typedef struct {
        bit                hit;
        logic [SLOT_W-1:0] slot;
        bit                by_subnet;
    } route_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = OP_LOOKUP;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;

    // shadow of the peer table; subnets start out zero like the block's
    bit                 shadow_valid [PEER_SLOTS_DEF];
    logic [ADDR_W-1:0]  shadow_addr  [PEER_SLOTS_DEF];
    int                 shadow_count [PEER_SLOTS_DEF];
    bit   [ADDR_W-1:0]  shadow_dst   [PEER_SLOTS_DEF*NETS];
    bit   [ADDR_W-1:0]  shadow_mask  [PEER_SLOTS_DEF*NETS];

    beat_t         pending_beats[$];
    route_t        expected_routes[$];
    logic [31:0]   known_addrs[$];
    beat_t         cur_beat;

    int items_accepted = 0;
    int total_items    = 0;
    int hold_left      = 0;
    bit hold_done      = 0;
    int error_count    = 0;
    int cycle_count    = 0;
    int lookups_seen   = 0;
    int subnet_hits    = 0;
    int address_hits   = 0;
    int misses         = 0;

    subnet_route_table_lookup uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #10 clk = ~clk;

    function automatic int sender_idle_pct();
        if (items_accepted < total_items / 3)
            return 16;
        else if (items_accepted < 2 * total_items / 3)
            return 76;
        return 0;
    endfunction

    function automatic int receiver_idle_pct();
        if (items_accepted < total_items / 3)
            return 76;
        else if (items_accepted < 2 * total_items / 3)
            return 16;
        return 0;
    endfunction

    function automatic logic [31:0] prefix_mask(input int len);
        if (len <= 0)
            return 32'd0;
        return 32'hFFFF_FFFF << (32 - len);
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("[%0t] mismatch on lookup %0d: %s got %0h expected %0h",
                 $realtime, lookups_seen, what, got, want);
        error_count++;
    endtask

    // Update the shadow table; for a lookup, scan it and queue the route.
    task automatic route_table_apply(input beat_t b);
        route_t r;
        int     p;
        int     j;
        int     k;
        bit     found;
        case (b.op)
            OP_WRITE_PEER:
            begin
                shadow_valid[b.peer_slot] = 1'b1;
                shadow_addr[b.peer_slot]  = b.address;
                shadow_count[b.peer_slot] = (b.subnet_count > NETS) ? NETS
                                                                   : b.subnet_count;
            end
            OP_WRITE_SUBNET:
            begin
                shadow_dst[b.peer_slot*NETS + b.subnet_slot]  = b.address;
                shadow_mask[b.peer_slot*NETS + b.subnet_slot] = b.subnet_mask;
            end
            OP_CLEAR_PEER:
                shadow_valid[b.peer_slot] = 1'b0;
            default:
            begin
                r.hit       = 1'b0;
                r.slot      = '0;
                r.by_subnet = 1'b0;
                found       = 1'b0;
                for (p = FIRST_SCANNED_SLOT; p < PEER_SLOTS_DEF && !found; p++)
                begin
                    if (shadow_valid[p])
                    begin
                        for (j = 0; j < shadow_count[p] && !found; j++)
                        begin
                            k = p * NETS + j;
                            if ((b.address & shadow_mask[k]) ==
                                (shadow_dst[k] & shadow_mask[k]))
                            begin
                                found       = 1'b1;
                                r.by_subnet = 1'b1;
                                r.slot      = p[SLOT_W-1:0];
                            end
                        end
                        if (!found && b.address == shadow_addr[p])
                        begin
                            found  = 1'b1;
                            r.slot = p[SLOT_W-1:0];
                        end
                    end
                end
                r.hit = found;
                expected_routes.push_back(r);
            end
        endcase
    endtask

    task automatic add_beat(input op_t op, input int ps, input int ss,
                            input logic [31:0] addr, input logic [31:0] mask,
                            input int cnt, input bit drain);
        beat_t b;
        b.op           = op;
        b.peer_slot    = ps[SLOT_W-1:0];
        b.subnet_slot  = ss[SUB_W-1:0];
        b.address      = addr;
        b.subnet_mask  = mask;
        b.subnet_count = cnt[COUNT_W-1:0];
        b.drain_first  = drain;
        pending_beats.push_back(b);
        if (op == OP_WRITE_PEER || op == OP_WRITE_SUBNET)
            known_addrs.push_back(addr);
    endtask

    // driver: present beats from the pending queue, hold until taken
    always @(posedge clk or negedge rst_n)
    begin
        beat_t nxt;
        bit    gap;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= OP_LOOKUP;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                route_table_apply(cur_beat);
                items_accepted <= items_accepted + 1;
            end
            if (!s_tvalid || s_tready)
            begin
                gap = ($urandom_range(99) < sender_idle_pct());
                if (pending_beats.size() != 0 && !gap &&
                    !(pending_beats[0].drain_first && expected_routes.size() != 0))
                begin
                    nxt      = pending_beats.pop_front();
                    cur_beat = nxt;
                    s_tvalid <= 1'b1;
                    s_tdata  <= {7'd0, nxt.subnet_count, nxt.subnet_mask, nxt.address,
                                 nxt.subnet_slot, nxt.peer_slot};
                    s_tuser  <= nxt.op;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // long output hold-off once the run is in its no-idle stretch
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && total_items != 0 &&
                 items_accepted >= 5 * total_items / 6)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // monitor: score each result beat against the oldest expected route
    always @(posedge clk or negedge rst_n)
    begin
        route_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                lookups_seen++;
                if (expected_routes.size() == 0)
                begin
                    report_mismatch("unexpected result beat", m_tdata, 0);
                end
                else
                begin
                    want = expected_routes.pop_front();
                    if (m_tdata[0] !== want.hit)
                        report_mismatch("hit", m_tdata[0], want.hit);
                    if (m_tdata[4:1] !== want.slot)
                        report_mismatch("matched_slot", m_tdata[4:1], want.slot);
                    if (m_tdata[5] !== want.by_subnet)
                        report_mismatch("by_subnet", m_tdata[5], want.by_subnet);
                    if (!want.hit)
                        misses++;
                    else if (want.by_subnet)
                        subnet_hits++;
                    else
                        address_hits++;
                end
            end
            if (hold_left != 0)
                m_tready <= 1'b0;
            else
                m_tready <= ($urandom_range(99) >= receiver_idle_pct());
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d routes outstanding",
                     cycle_count, expected_routes.size());
            $display("tb_subnet_route_table_lookup: FAIL");
            $finish;
        end
    end

    initial
    begin
        int          kind;
        int          cnt;
        int          ps;
        int          len;
        logic [31:0] a;
        logic [31:0] m;
        bit          drain;

        // empty table, field extremes
        add_beat(OP_LOOKUP, 0, 0, 32'h0000_0000, 32'h0, 0, 0);
        add_beat(OP_LOOKUP, 15, 3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7, 0);
        // reserved slots are stored but never scanned
        add_beat(OP_WRITE_PEER, 0, 0, 32'h0A00_0001, 32'h0, 0, 0);
        add_beat(OP_WRITE_PEER, 1, 0, 32'h0A00_0002, 32'h0, 4, 0);
        add_beat(OP_LOOKUP, 0, 0, 32'h0A00_0001, 32'h0, 0, 0);
        add_beat(OP_LOOKUP, 1, 0, 32'h0A00_0002, 32'h0, 0, 0);
        // oversized count saturates; untouched subnets have a zero mask
        add_beat(OP_WRITE_SUBNET, 15, 3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0);
        add_beat(OP_WRITE_PEER, 15, 0, 32'hFFFF_FFFF, 32'h0, 7, 0);
        add_beat(OP_LOOKUP, 0, 0, 32'h1234_5678, 32'h0, 0, 0);
        // own address match, then subnet ignored while count is zero
        add_beat(OP_WRITE_PEER, 2, 0, 32'hC0A8_0001, 32'h0, 0, 0);
        add_beat(OP_LOOKUP, 0, 0, 32'hC0A8_0001, 32'h0, 0, 0);
        add_beat(OP_WRITE_SUBNET, 2, 0, 32'hC0A8_0100, 32'hFFFF_FF00, 0, 0);
        add_beat(OP_LOOKUP, 0, 0, 32'hC0A8_01AB, 32'h0, 0, 0);
        add_beat(OP_WRITE_PEER, 2, 0, 32'hC0A8_0001, 32'h0, 1, 0);
        add_beat(OP_LOOKUP, 0, 0, 32'hC0A8_01AB, 32'h0, 0, 0);
        // clear keeps subnets; a rewrite brings them back
        add_beat(OP_CLEAR_PEER, 15, 0, 32'h0, 32'h0, 0, 0);
        add_beat(OP_LOOKUP, 0, 0, 32'h1234_5678, 32'h0, 0, 1);
        add_beat(OP_WRITE_PEER, 15, 0, 32'h0000_0000, 32'h0, 5, 0);
        add_beat(OP_LOOKUP, 0, 0, 32'h55AA_55AA, 32'h0, 0, 0);
        add_beat(OP_CLEAR_PEER, 2, 0, 32'h0, 32'h0, 0, 0);
        add_beat(OP_LOOKUP, 0, 0, 32'hC0A8_01AB, 32'h0, 0, 0);
        add_beat(OP_CLEAR_PEER, 15, 0, 32'h0, 32'h0, 0, 0);
        add_beat(OP_CLEAR_PEER, 0, 0, 32'h0, 32'h0, 0, 0);
        add_beat(OP_LOOKUP, 0, 0, 32'h0000_0000, 32'h0, 0, 0);

        total_items = pending_beats.size() + RANDOM_BEATS;
        while (pending_beats.size() < total_items)
        begin
            kind  = $urandom_range(99);
            ps    = $urandom_range(PEER_SLOTS_DEF - 1);
            drain = (pending_beats.size() == 25) || ($urandom_range(79) == 0);
            if (kind < 30)
            begin
                // program a peer: its subnets first, then the peer itself
                cnt = $urandom_range(7);
                for (int j = 0; j < ((cnt > NETS) ? NETS : cnt); j++)
                begin
                    len = ($urandom_range(9) == 0) ? $urandom_range(7)
                                                   : $urandom_range(32, 8);
                    m   = ($urandom_range(4) == 0) ? $urandom() : prefix_mask(len);
                    add_beat(OP_WRITE_SUBNET, ps, j, $urandom(), m, $urandom_range(7),
                             j == 0 && drain);
                end
                add_beat(OP_WRITE_PEER, ps, $urandom_range(3), $urandom(), $urandom(),
                         cnt, drain && cnt == 0);
            end
            else if (kind < 38)
            begin
                add_beat(OP_CLEAR_PEER, ps, $urandom_range(3), $urandom(), $urandom(),
                         $urandom_range(7), drain);
            end
            else if (kind < 43)
            begin
                len = $urandom_range(32);
                add_beat(OP_WRITE_SUBNET, ps, $urandom_range(3), $urandom(),
                         prefix_mask(len), $urandom_range(7), drain);
            end
            else if (kind < 47)
            begin
                add_beat(OP_WRITE_PEER, ps, $urandom_range(3), $urandom(), $urandom(),
                         $urandom_range(7), drain);
            end
            else
            begin
                kind = $urandom_range(99);
                if (known_addrs.size() == 0 || kind >= 70)
                    a = $urandom();
                else if (kind < 40)
                    a = known_addrs[$urandom_range(known_addrs.size() - 1)];
                else
                    a = known_addrs[$urandom_range(known_addrs.size() - 1)]
                        ^ $urandom_range(255);
                add_beat(OP_LOOKUP, ps, $urandom_range(3), a, $urandom(),
                         $urandom_range(7), drain);
            end
        end
        total_items = pending_beats.size();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_beats.size() != 0 || s_tvalid)
            @(posedge clk);
        while (expected_routes.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("sent %0d beats of all four kinds, including a %0d-cycle output hold",
                 total_items, HOLD_CYCLES);
        $display("checked %0d lookups: %0d subnet hits, %0d own-address hits, %0d misses",
                 lookups_seen, subnet_hits, address_hits, misses);
        if (error_count == 0)
            $display("tb_subnet_route_table_lookup: PASS");
        else
            $display("tb_subnet_route_table_lookup: FAIL");
        $finish;
    end

endmodule
